>>> hdl/lspc_pkg.sv
// Shared definitions for the laser scan polar-to-Cartesian converter.
// Holds widths, fixed-point constants, register codes, the sequencer state type,
// the CORDIC arctangent table and the rounding helper. No dependencies.
`timescale 1ns / 1ps

package lspc_pkg;

  localparam int MAX_SAMPLES_DEF = 512;

  localparam int IDX_W   = 10;
  localparam int RANGE_W = 23;
  localparam int XY_W    = 24;
  localparam int Z_W     = 25;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SCAN_W  = 27;

  localparam logic [IDX_W-1:0]   IDX_MAX = '1;
  localparam logic [RANGE_W-1:0] NONE23  = '1;

  localparam int CORDIC_N = 16;
  localparam logic signed [MUL_W-1:0] CORDIC_X0 = 32'sd652032874;

  localparam int TURN_CDEG    = 36000;
  localparam int HALF_CDEG    = 18000;
  localparam int QUARTER_CDEG = 9000;

  // ceil(2^44 / 36000): the quotient of a 27-bit angle sum by a full turn is exact.
  localparam int RECIP_SHIFT = 44;
  localparam logic [MUL_W-1:0] RECIP_TURN = 32'd488671835;

  localparam int ROUND_SHIFT = 30;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] CFG_RANGE_UNIT  = 2'd2;
  localparam logic [1:0] CFG_SCAN_COUNT  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_IDX,
    S_MUL_RNG,
    S_MUL_REC,
    S_MUL_Q,
    S_REDUCE,
    S_WRAP,
    S_CORDIC,
    S_MUL_X,
    S_MUL_Y,
    S_CAP_Y,
    S_DONE
  } lspc_state_t;

  // Arctangent of 2^-k in units of 1/256 centidegree.
  function automatic logic [20:0] atan_lut(input logic [3:0] k);
    logic [20:0] v;
    unique case (k)
      4'd0:  v = 21'd1152000;
      4'd1:  v = 21'd680065;
      4'd2:  v = 21'd359328;
      4'd3:  v = 21'd182400;
      4'd4:  v = 21'd91554;
      4'd5:  v = 21'd45822;
      4'd6:  v = 21'd22916;
      4'd7:  v = 21'd11459;
      4'd8:  v = 21'd5730;
      4'd9:  v = 21'd2865;
      4'd10: v = 21'd1432;
      4'd11: v = 21'd716;
      4'd12: v = 21'd358;
      4'd13: v = 21'd179;
      4'd14: v = 21'd90;
      4'd15: v = 21'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Divide a magnitude product by 2^30, round half up, then apply the sign.
  function automatic logic [XY_W-1:0] round_scale(input logic [PROD_W-1:0] p,
                                                  input logic neg);
    logic [PROD_W-1:0] q;
    logic [XY_W-1:0]   mag;
    q   = (p + (PROD_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    mag = q[XY_W-1:0];
    return neg ? (~mag + XY_W'(1)) : mag;
  endfunction

endpackage

>>> hdl/lspc_mul.sv
// Shared unsigned 32 x 32 multiplier with a registered product.
// Every product of the converter goes through this unit. Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lspc_pkg::MUL_W-1:0]  a,
  input  logic [lspc_pkg::MUL_W-1:0]  b,
  output logic [lspc_pkg::PROD_W-1:0] p
);
  import lspc_pkg::*;

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign p = p_r;

endmodule

>>> hdl/lspc_cordic.sv
// Iterative CORDIC rotator: one micro-rotation per cycle, sixteen in all.
// Produces gain-compensated cosine and sine scaled by 2^30. Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [lspc_pkg::Z_W-1:0]   z_init,
  output logic                              done,
  output logic signed [lspc_pkg::MUL_W-1:0] x,
  output logic signed [lspc_pkg::MUL_W-1:0] y
);
  import lspc_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [3:0]              k_r;
  logic signed [MUL_W-1:0] x_r;
  logic signed [MUL_W-1:0] y_r;
  logic signed [Z_W-1:0]   z_r;

  logic signed [MUL_W-1:0] dx;
  logic signed [MUL_W-1:0] dy;
  logic signed [Z_W-1:0]   angle;

  // Arithmetic shifts round toward minus infinity, as the fixed-point scheme needs.
  assign dx    = y_r >>> k_r;
  assign dy    = x_r >>> k_r;
  assign angle = signed'(Z_W'(atan_lut(k_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 4'd1;
        if (k_r == 4'(CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CORDIC_X0;
      y_r <= '0;
      z_r <= z_init;
    end else if (busy_r) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - angle;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + angle;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;

endmodule

>>> hdl/laser_scan_polar_to_cartesian.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  first_of_scan, range_raw, intensity_in
// out      output     out_valid/out_stall  index, range, bearing, x, y, intensity, flags, minima
// cfg      input      cfg_valid/cfg_ready  cfg_index (2 bits), cfg_data (16 bits)
//
// A sample in the scan passes through the sixteen CORDIC micro-rotations and through the
// shared multiplier, which serves six products in turn; a sample past the scan count or the
// store limit goes straight to the done state. in_stall is high from the transfer until the
// result is loaded into the output register, so the next sample can be taken while a result
// waits on out_stall.
// Reset (rst_n, synchronous, active low) restores the register defaults, clears the index
// and sets both minima to "none"; no clearing pass is needed.
`timescale 1ns / 1ps

module laser_scan_polar_to_cartesian #(
  parameter int MAX_SAMPLES = lspc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_first_of_scan,
  input  logic [15:0]                         in_range_raw,
  input  logic [7:0]                          in_intensity_in,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lspc_pkg::IDX_W-1:0]          out_sample_index,
  output logic [lspc_pkg::RANGE_W-1:0]        out_range_mm,
  output logic signed [15:0]                  out_bearing_cdeg,
  output logic signed [lspc_pkg::XY_W-1:0]    out_x_mm,
  output logic signed [lspc_pkg::XY_W-1:0]    out_y_mm,
  output logic [7:0]                          out_intensity_out,
  output logic                                out_beyond_count,
  output logic [lspc_pkg::RANGE_W-1:0]        out_min_left_mm,
  output logic [lspc_pkg::RANGE_W-1:0]        out_min_right_mm,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);
  import lspc_pkg::*;

  // Configuration registers.
  logic signed [15:0] start_r;
  logic [15:0]        step_r;
  logic [6:0]         unit_r;
  logic [IDX_W-1:0]   scan_r;

  // Sequencer and scan state.
  lspc_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [RANGE_W-1:0] min_left_r, min_left_nxt;
  logic [RANGE_W-1:0] min_right_r, min_right_nxt;

  // Per-sample working registers.
  logic [IDX_W-1:0]   cur_idx_r;
  logic [15:0]        raw_r;
  logic [7:0]         inten_r;
  logic               beyond_r;
  logic [SCAN_W-1:0]  s_r;
  logic [RANGE_W-1:0] range_r;
  logic signed [15:0] bearing_r;
  logic               flip_r;
  logic [XY_W-1:0]    x_res_r;
  logic [XY_W-1:0]    y_res_r;

  // Output register.
  logic               out_valid_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic [RANGE_W-1:0] o_range_r;
  logic [15:0]        o_bearing_r;
  logic [XY_W-1:0]    o_x_r;
  logic [XY_W-1:0]    o_y_r;
  logic [7:0]         o_inten_r;
  logic               o_beyond_r;
  logic [RANGE_W-1:0] o_min_left_r;
  logic [RANGE_W-1:0] o_min_right_r;

  // Handshake and datapath nets.
  logic               in_fire;
  logic               out_free;
  logic [IDX_W-1:0]   cur_idx_w;
  logic               beyond_w;
  logic               mul_en;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [MUL_W-1:0] cordic_x;
  logic signed [MUL_W-1:0] cordic_y;
  logic signed [27:0] s_sum;
  logic signed [27:0] s_wrap;
  logic [SCAN_W-1:0]  m_full;
  logic signed [16:0] m_wide;
  logic signed [15:0] b_fold;
  logic               flip_w;
  logic signed [Z_W-1:0] z_init;
  logic signed [MUL_W-1:0] cx;
  logic signed [MUL_W-1:0] cy;
  logic [MUL_W-1:0]   cx_mag;
  logic [MUL_W-1:0]   cy_mag;
  logic [IDX_W-1:0]   half_w;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // A start-of-scan mark restarts the index at zero for this very sample.
  assign cur_idx_w = in_first_of_scan ? '0 : idx_r;
  assign beyond_w  = (cur_idx_w >= scan_r) ||
                     ({1'b0, cur_idx_w} >= (IDX_W + 1)'(MAX_SAMPLES));

  // Bearing sum: start plus index times step, lifted to non-negative before reduction.
  assign s_sum  = 28'(start_r) + signed'({2'b00, mul_p[25:0]});
  assign s_wrap = s_sum[27] ? (s_sum + 28'sd36000) : s_sum;

  // Remainder after the exact quotient, then mapped into [-18000, 17999].
  assign m_full = s_r - mul_p[SCAN_W-1:0];
  always_comb begin
    m_wide = signed'({1'b0, m_full[15:0]});
    if (m_wide >= 17'(HALF_CDEG)) begin
      m_wide = m_wide - 17'(TURN_CDEG);
    end
  end

  // Fold into the CORDIC's convergence range; the result is negated afterward.
  always_comb begin
    b_fold = bearing_r;
    flip_w = 1'b0;
    if (bearing_r > 16'(QUARTER_CDEG)) begin
      b_fold = bearing_r - 16'(HALF_CDEG);
      flip_w = 1'b1;
    end else if (bearing_r < -16'(QUARTER_CDEG)) begin
      b_fold = bearing_r + 16'(HALF_CDEG);
      flip_w = 1'b1;
    end
  end
  assign z_init = signed'({{(Z_W - 24){b_fold[15]}}, b_fold, 8'h00});

  assign cx     = flip_r ? -cordic_x : cordic_x;
  assign cy     = flip_r ? -cordic_y : cordic_y;
  assign cx_mag = cx[MUL_W-1] ? MUL_W'(-cx) : MUL_W'(cx);
  assign cy_mag = cy[MUL_W-1] ? MUL_W'(-cy) : MUL_W'(cy);

  // Nearest-range tracking; the middle sample counts toward neither side.
  assign half_w = scan_r >> 1;
  always_comb begin
    min_left_nxt  = min_left_r;
    min_right_nxt = min_right_r;
    if (!beyond_r) begin
      if (cur_idx_r > half_w) begin
        if (range_r < min_left_r) min_left_nxt = range_r;
      end else if (cur_idx_r < half_w) begin
        if (range_r < min_right_r) min_right_nxt = range_r;
      end
    end
  end

  lspc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  lspc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .z_init (z_init),
    .done   (cordic_done),
    .x      (cordic_x),
    .y      (cordic_y)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire) state_nxt = beyond_w ? S_DONE : S_MUL_IDX;
      S_MUL_IDX: state_nxt = S_MUL_RNG;
      S_MUL_RNG: state_nxt = S_MUL_REC;
      S_MUL_REC: state_nxt = S_MUL_Q;
      S_MUL_Q:   state_nxt = S_REDUCE;
      S_REDUCE:  state_nxt = S_WRAP;
      S_WRAP:    state_nxt = S_CORDIC;
      S_CORDIC:  if (cordic_done) state_nxt = S_MUL_X;
      S_MUL_X:   state_nxt = S_MUL_Y;
      S_MUL_Y:   state_nxt = S_CAP_Y;
      S_CAP_Y:   state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: operand selection for the shared multiplier and CORDIC launch.
  always_comb begin
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    unique case (state_r)
      S_MUL_IDX: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(cur_idx_r);
        mul_b  = MUL_W'(step_r);
      end
      S_MUL_RNG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(raw_r);
        mul_b  = MUL_W'(unit_r);
      end
      S_MUL_REC: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(s_r);
        mul_b  = RECIP_TURN;
      end
      S_MUL_Q: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mul_p[RECIP_SHIFT+11:RECIP_SHIFT]);
        mul_b  = MUL_W'(TURN_CDEG);
      end
      S_WRAP: begin
        cordic_start = 1'b1;
      end
      S_MUL_X: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(range_r);
        mul_b  = cx_mag;
      end
      S_MUL_Y: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(range_r);
        mul_b  = cy_mag;
      end
      default: begin
      end
    endcase
  end

  // Control state, scan state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      min_left_r  <= NONE23;
      min_right_r <= NONE23;
      out_valid_r <= 1'b0;
      start_r     <= -16'sd9000;
      step_r      <= 16'd50;
      unit_r      <= 7'd1;
      scan_r      <= 10'd361;
    end else begin
      state_r <= state_nxt;

      if (in_fire) begin
        idx_r <= (cur_idx_w == IDX_MAX) ? cur_idx_w : cur_idx_w + IDX_W'(1);
        if (in_first_of_scan) begin
          min_left_r  <= NONE23;
          min_right_r <= NONE23;
        end
      end

      if (state_r == S_DONE && out_free) begin
        min_left_r  <= min_left_nxt;
        min_right_r <= min_right_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_ANGLE: start_r <= signed'(cfg_data);
          CFG_ANGLE_STEP:  step_r  <= cfg_data;
          CFG_RANGE_UNIT:  unit_r  <= cfg_data[6:0];
          CFG_SCAN_COUNT:  scan_r  <= cfg_data[IDX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Per-sample datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_idx_r <= cur_idx_w;
      raw_r     <= in_range_raw;
      inten_r   <= in_intensity_in;
      beyond_r  <= beyond_w;
    end
    if (state_r == S_MUL_RNG) s_r       <= s_wrap[SCAN_W-1:0];
    if (state_r == S_MUL_REC) range_r   <= mul_p[RANGE_W-1:0];
    if (state_r == S_REDUCE)  bearing_r <= m_wide[15:0];
    if (state_r == S_WRAP)    flip_r    <= flip_w;
    if (state_r == S_MUL_Y)   x_res_r   <= round_scale(mul_p, cx[MUL_W-1]);
    if (state_r == S_CAP_Y)   y_res_r   <= round_scale(mul_p, cy[MUL_W-1]);
  end

  // Output register; out-of-scan samples report zero geometry.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      o_idx_r       <= cur_idx_r;
      o_range_r     <= beyond_r ? '0 : range_r;
      o_bearing_r   <= beyond_r ? '0 : bearing_r;
      o_x_r         <= beyond_r ? '0 : x_res_r;
      o_y_r         <= beyond_r ? '0 : y_res_r;
      o_inten_r     <= inten_r;
      o_beyond_r    <= beyond_r;
      o_min_left_r  <= min_left_nxt;
      o_min_right_r <= min_right_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_index  = o_idx_r;
  assign out_range_mm      = o_range_r;
  assign out_bearing_cdeg  = signed'(o_bearing_r);
  assign out_x_mm          = signed'(o_x_r);
  assign out_y_mm          = signed'(o_y_r);
  assign out_intensity_out = o_inten_r;
  assign out_beyond_count  = o_beyond_r;
  assign out_min_left_mm   = o_min_left_r;
  assign out_min_right_mm  = o_min_right_r;

  // The block holds off the input for the whole computation of a sample.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input taken again right after a transfer");

  // Samples outside the scan carry no geometry.
  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beyond_count) |->
      (out_range_mm == '0 && out_bearing_cdeg == 16'sd0 &&
       out_x_mm == '0 && out_y_mm == '0))
    else $error("out-of-scan sample with nonzero geometry");

  // A delivered bearing always lies within one wrapped turn.
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beyond_count) |->
      (out_bearing_cdeg >= -16'sd18000 && out_bearing_cdeg <= 16'sd17999))
    else $error("bearing outside one turn");

  // The CORDIC finishes only while the sequencer waits for it.
  a_cordic_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == S_CORDIC))
    else $error("CORDIC completion outside its wait state");

  // Finishing a sample always presents a result on the next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished sample not presented");

endmodule
